### hw/rtl/urxtrap_pkg.sv
package urxtrap_pkg;

  localparam int unsigned FifoDepthDef = 64;

  // request string: ESC, ASCII text, CR LF
  localparam int unsigned ReqLen = 31;
  localparam int unsigned McW    = 5;
  localparam logic [7:0] EscByte = 8'h1B;

  // one padding entry so a 5-bit index never leaves the array
  localparam logic [7:0] ReqSeq [32] = '{
    8'h1B, 8'h43, 8'h50, 8'h38, 8'h30, 8'h30, 8'h30, 8'h5F,
    8'h55, 8'h50, 8'h4C, 8'h4F, 8'h41, 8'h44, 8'h5F, 8'h52,
    8'h45, 8'h53, 8'h45, 8'h54, 8'h3A, 8'h38, 8'h46, 8'h33,
    8'h41, 8'h39, 8'h31, 8'h43, 8'h37, 8'h0D, 8'h0A, 8'h00
  };

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PORT_EN = 2'd0,
    CFG_TRAP_EN = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_RX   = 2'd0,
    OP_READ = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  // classified line byte or host request, handed from front to back
  typedef struct packed {
    logic [1:0]     op;
    logic [7:0]     rx_byte;
    logic [McW-1:0] replay_len;
    logic           queue_it;
    logic           trap_hit;
  } cmd_t;

endpackage

### hw/rtl/urxtrap_if.sv
interface urxtrap_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface urxtrap_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  logic       data_valid;
  logic [6:0] available_count;
  logic       dropped;
  logic       reset_request;

  modport source (output valid, output data, output data_valid,
                  output available_count, output dropped,
                  output reset_request, input ready);
  modport sink   (input valid, input data, input data_valid,
                  input available_count, input dropped,
                  input reset_request, output ready);
endinterface

### hw/rtl/urxtrap_front.sv
module urxtrap_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  urxtrap_pkg::cfg_wr_t  cfg_i,
  urxtrap_in_if.sink            in_i,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i,
  output urxtrap_pkg::cmd_t     cmd_o
);

  logic                        trap_en_q, trap_en_d;
  logic [urxtrap_pkg::McW-1:0] mc_q, mc_d;
  logic [urxtrap_pkg::McW-1:0] mc_eff;
  logic [urxtrap_pkg::McW-1:0] mc_inc;
  logic                        fire;

  assign in_i.ready  = cmd_ready_i;
  assign cmd_valid_o = in_i.valid;
  assign fire        = in_i.valid && cmd_ready_i;

  assign mc_eff = (mc_q >= urxtrap_pkg::McW'(urxtrap_pkg::ReqLen)) ? '0 : mc_q;
  assign mc_inc = mc_eff + urxtrap_pkg::McW'(1);

  always_comb begin
    cmd_o.op         = in_i.op;
    cmd_o.rx_byte    = in_i.rx_byte;
    cmd_o.replay_len = '0;
    cmd_o.queue_it   = 1'b1;
    cmd_o.trap_hit   = 1'b0;
    mc_d             = mc_q;
    trap_en_d        = trap_en_q;

    if (in_i.op == urxtrap_pkg::OP_RX && trap_en_q) begin
      if (in_i.rx_byte == urxtrap_pkg::ReqSeq[mc_eff]) begin
        cmd_o.queue_it = 1'b0;
        if (mc_inc == urxtrap_pkg::McW'(urxtrap_pkg::ReqLen)) begin
          cmd_o.trap_hit = 1'b1;
          mc_d           = '0;
        end else begin
          mc_d = mc_inc;
        end
      end else begin
        // held prefix goes back into the fifo; ESC starts a new match
        cmd_o.replay_len = mc_eff;
        if (in_i.rx_byte == urxtrap_pkg::EscByte) begin
          mc_d           = urxtrap_pkg::McW'(1);
          cmd_o.queue_it = 1'b0;
        end else begin
          mc_d = '0;
        end
      end
    end

    if (!fire) begin
      mc_d = mc_q;
    end

    if (cfg_i.we) begin
      case (cfg_i.idx)
        urxtrap_pkg::CFG_PORT_EN: mc_d = '0;
        urxtrap_pkg::CFG_TRAP_EN: trap_en_d = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trap_en_q <= 1'b1;
      mc_q      <= '0;
    end else begin
      trap_en_q <= trap_en_d;
      mc_q      <= mc_d;
    end
  end

endmodule

### hw/rtl/urxtrap_cmdq.sv
module urxtrap_cmdq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  urxtrap_pkg::cmd_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output urxtrap_pkg::cmd_t pop_data_o
);

  // two-entry queue between classifier and executor
  urxtrap_pkg::cmd_t slot_q [2];
  logic              wr_q, wr_d;
  logic              rd_q, rd_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

### hw/rtl/urxtrap_back.sv
module urxtrap_back #(
  parameter int unsigned FIFO_DEPTH = urxtrap_pkg::FifoDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  urxtrap_pkg::cfg_wr_t cfg_i,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  urxtrap_pkg::cmd_t    cmd_i,
  urxtrap_out_if.source        out_o
);

  localparam int unsigned AW  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned AvW = (CW + 1 > 8) ? CW + 1 : 8;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_REPLAY = 4'b0010,
    S_EXEC   = 4'b0100,
    S_RDWAIT = 4'b1000
  } state_e;

  state_e                      state_q, state_d;
  urxtrap_pkg::cmd_t           cmd_q, cmd_d;
  logic [urxtrap_pkg::McW-1:0] rep_q, rep_d;
  logic [AW-1:0]               wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]               rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic                        peek_full_q, peek_full_d;
  logic [7:0]                  peek_byte_q, peek_byte_d;
  logic                        port_en_q, port_en_d;

  logic [7:0]                  mem [FIFO_DEPTH];
  logic [7:0]                  rd_data_q;
  logic                        mem_we, mem_re;
  logic [7:0]                  mem_wdata;

  logic                        out_valid_q;
  logic [7:0]                  out_data_q;
  logic                        out_dv_q;
  logic [6:0]                  out_avail_q;
  logic                        out_drop_q;
  logic                        out_rst_q;

  logic                        out_free;
  logic                        res_load;
  logic [7:0]                  res_data;
  logic                        res_dv;
  logic                        res_drop;
  logic                        res_rst;
  logic [6:0]                  res_avail;
  logic [AvW-1:0]              avail_sum;
  logic                        fifo_full;
  logic                        fifo_empty;
  logic [AW-1:0]               wr_ptr_inc;
  logic [AW-1:0]               rd_ptr_inc;

  assign out_free    = !out_valid_q || out_o.ready;
  assign cmd_ready_o = (state_q == S_IDLE);
  assign fifo_full   = (cnt_q == CW'(FIFO_DEPTH));
  assign fifo_empty  = (cnt_q == '0);
  assign wr_ptr_inc  = (wr_ptr_q == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
  assign rd_ptr_inc  = (rd_ptr_q == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    rep_d       = rep_q;
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    cnt_d       = cnt_q;
    peek_full_d = peek_full_q;
    peek_byte_d = peek_byte_q;
    port_en_d   = port_en_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_wdata   = cmd_q.rx_byte;
    res_load    = 1'b0;
    res_data    = 8'h00;
    res_dv      = 1'b0;
    res_drop    = 1'b0;
    res_rst     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          rep_d = '0;
          if (port_en_q && cmd_i.replay_len != '0) begin
            state_d = S_REPLAY;
          end else begin
            state_d = S_EXEC;
          end
        end
      end

      S_REPLAY: begin
        // bytes that find the fifo full are lost
        if (!fifo_full) begin
          mem_we    = 1'b1;
          mem_wdata = urxtrap_pkg::ReqSeq[rep_q];
          wr_ptr_d  = wr_ptr_inc;
          cnt_d     = cnt_q + CW'(1);
        end
        rep_d = rep_q + urxtrap_pkg::McW'(1);
        if (rep_d == cmd_q.replay_len) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
          case (cmd_q.op)
            urxtrap_pkg::OP_RX: begin
              if (cmd_q.trap_hit) begin
                res_rst     = 1'b1;
                wr_ptr_d    = '0;
                rd_ptr_d    = '0;
                cnt_d       = '0;
                peek_full_d = 1'b0;
                peek_byte_d = 8'h00;
              end else if (cmd_q.queue_it && port_en_q) begin
                if (fifo_full) begin
                  res_drop = 1'b1;
                end else begin
                  mem_we   = 1'b1;
                  wr_ptr_d = wr_ptr_inc;
                  cnt_d    = cnt_q + CW'(1);
                end
              end
            end
            urxtrap_pkg::OP_READ: begin
              if (port_en_q) begin
                if (peek_full_q) begin
                  res_data    = peek_byte_q;
                  res_dv      = 1'b1;
                  peek_full_d = 1'b0;
                  peek_byte_d = 8'h00;
                end else if (!fifo_empty) begin
                  mem_re   = 1'b1;
                  rd_ptr_d = rd_ptr_inc;
                  cnt_d    = cnt_q - CW'(1);
                  res_load = 1'b0;
                  state_d  = S_RDWAIT;
                end
              end
            end
            urxtrap_pkg::OP_PEEK: begin
              if (port_en_q) begin
                if (peek_full_q) begin
                  res_data = peek_byte_q;
                  res_dv   = 1'b1;
                end else if (!fifo_empty) begin
                  mem_re   = 1'b1;
                  rd_ptr_d = rd_ptr_inc;
                  cnt_d    = cnt_q - CW'(1);
                  res_load = 1'b0;
                  state_d  = S_RDWAIT;
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_RDWAIT: begin
        if (out_free) begin
          res_load = 1'b1;
          res_data = rd_data_q;
          res_dv   = 1'b1;
          state_d  = S_IDLE;
          if (cmd_q.op == urxtrap_pkg::OP_PEEK) begin
            peek_full_d = 1'b1;
            peek_byte_d = rd_data_q;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (cfg_i.we && cfg_i.idx == urxtrap_pkg::CFG_PORT_EN) begin
      port_en_d   = cfg_i.data[0];
      wr_ptr_d    = '0;
      rd_ptr_d    = '0;
      cnt_d       = '0;
      peek_full_d = 1'b0;
      peek_byte_d = 8'h00;
    end
  end

  // count after this transaction, saturated to the output field; zero while the port is disabled
  always_comb begin
    avail_sum = AvW'(cnt_d) + AvW'(peek_full_d);
    if (!port_en_q) begin
      res_avail = 7'd0;
    end else if (avail_sum > AvW'(127)) begin
      res_avail = 7'h7F;
    end else begin
      res_avail = avail_sum[6:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rep_q       <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
      peek_full_q <= 1'b0;
      peek_byte_q <= 8'h00;
      port_en_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rep_q       <= rep_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      cnt_q       <= cnt_d;
      peek_full_q <= peek_full_d;
      peek_byte_q <= peek_byte_d;
      port_en_q   <= port_en_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (res_load) begin
      out_data_q  <= res_data;
      out_dv_q    <= res_dv;
      out_avail_q <= res_avail;
      out_drop_q  <= res_drop;
      out_rst_q   <= res_rst;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_ptr_q] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[rd_ptr_q];
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.data            = out_data_q;
  assign out_o.data_valid      = out_dv_q;
  assign out_o.available_count = out_avail_q;
  assign out_o.dropped         = out_drop_q;
  assign out_o.reset_request   = out_rst_q;

endmodule

### hw/rtl/uart_rx_fifo_with_magic_sequence_trap_unit.sv
// channel   dir  fields                                              
// in_i      in   op[1:0], rx_byte[7:0]                                
// out_o     out  data[7:0], data_valid, available_count[6:0],        
//                dropped, reset_request                              
// cfg       in   cfg_we_i, cfg_idx_i[1:0], cfg_data_i[0:0]            
//
// The result register loads once a transaction has passed the command queue,
// the command register, any replay of held request bytes on a mismatch (up
// to 30, via the single fifo write port) and the execute state, plus the
// read-wait state for a fifo-popping read or peek. Async active-low reset;
// fifo contents are not cleared, the pointers are. A two-entry command queue
// lets in_i accept during an output stall; a full queue drops in_i.ready.
module uart_rx_fifo_with_magic_sequence_trap_unit #(
  parameter int unsigned FIFO_DEPTH = urxtrap_pkg::FifoDepthDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [urxtrap_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [urxtrap_pkg::CfgDataW-1:0]     cfg_data_i,
  urxtrap_in_if.sink                           in_i,
  urxtrap_out_if.source                        out_o
);

  urxtrap_pkg::cfg_wr_t cfg;
  urxtrap_pkg::cmd_t    fr_cmd;
  urxtrap_pkg::cmd_t    bk_cmd;
  logic                 fr_valid, fr_ready;
  logic                 bk_valid, bk_ready;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  urxtrap_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  urxtrap_cmdq u_cmdq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_cmd),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_cmd)
  );

  urxtrap_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (bk_valid),
    .cmd_ready_o (bk_ready),
    .cmd_i       (bk_cmd),
    .out_o       (out_o)
  );

endmodule
